// File: rtl/bmcm_pkg.sv
// Shared types and constants for the binomial measure cell mass block.
// Used by bmcm_level, bmcm_skid and binomial_measure_cell_mass.
package bmcm_pkg;

    // Field widths
    localparam int MASS_W   = 33;   // unsigned Q1.32
    localparam int WEIGHT_W = 16;   // unsigned Q0.16
    localparam int FACTOR_W = 17;   // Q0.16 factor up to and including 1.0
    localparam int IDX_W    = 16;
    localparam int DEPTH_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W   = MASS_W + FACTOR_W;

    // Default pipeline depth (number of level stages)
    localparam int MAX_LEVELS_DEF = 16;

    // Fixed-point constants
    localparam logic [MASS_W-1:0]   MASS_ONE   = {1'b1, {(MASS_W-1){1'b0}}};
    localparam logic [FACTOR_W-1:0] WEIGHT_ONE = {1'b1, {(FACTOR_W-1){1'b0}}};

    // Register reset values
    localparam logic [WEIGHT_W-1:0] WEIGHT_P_RST     = 16'd32768;
    localparam logic [DEPTH_W-1:0]  DEPTH_LEVELS_RST = 5'd8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_P     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LEVELS = 2'd1;

    // One pipeline slot
    typedef struct packed {
        logic              valid;
        logic [MASS_W-1:0] mass;
        logic [IDX_W-1:0]  index;
    } bmcm_stage_t;

endpackage

// File: rtl/binomial_measure_cell_mass.sv
// Top level of the binomial measure cell mass block: config registers, input
// stage, level pipeline and output buffer. Depends on bmcm_pkg, bmcm_level, bmcm_skid.
//
// Usage:
//   Request channel: in_valid / in_stall with cell_index. A request is taken
//   at a clock edge where in_valid is high and in_stall is low.
//   Result channel: out_valid / out_stall with cell_mass (Q1.32) and
//   echo_index. A result leaves at an edge where out_valid is high and
//   out_stall is low.
//   Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   index 0 is weight_p, index 1 is depth_levels, others are ignored.
//   cfg_ready is always high. Write only while no request is in flight.
// Timing:
//   One request per cycle while in_stall is low. A request passes through the
//   input register, then one multiplier stage per level, then the output register.
// Reset clears all valid bits and loads weight_p = 0.5, depth_levels = 8.
// When out_stall is held, one more result lands in the skid slot, then
// in_stall rises and the whole pipeline holds until the output drains.
module binomial_measure_cell_mass
    import bmcm_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [IDX_W-1:0]      cell_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [MASS_W-1:0]     cell_mass,
    output logic [IDX_W-1:0]      echo_index,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(MAX_LEVELS);

    logic [WEIGHT_W-1:0] weight_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [DEPTH_W-1:0]  depth_eff;
    logic                advance;
    logic                skid_full;
    logic                in_valid_reg;
    logic [IDX_W-1:0]    in_index_reg;
    bmcm_stage_t         stage [0:MAX_LEVELS];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_P_RST;
            depth_reg  <= DEPTH_LEVELS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WEIGHT_P:     weight_reg <= cfg_data[WEIGHT_W-1:0];
                CFG_DEPTH_LEVELS: depth_reg  <= cfg_data[DEPTH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Depth saturates at the pipeline length
    assign depth_eff = (depth_reg > MAX_DEPTH) ? MAX_DEPTH : depth_reg;

    // Input register
    assign in_stall = skid_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_index_reg <= cell_index;
        end
    end

    assign stage[0].valid = in_valid_reg;
    assign stage[0].mass  = MASS_ONE;
    assign stage[0].index = in_index_reg;

    // One multiplier stage per level
    generate
        for (genvar lvl = 0; lvl < MAX_LEVELS; lvl++)
        begin : g_level
            bmcm_level #(
                .LEVEL (lvl)
            ) u_level (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .weight_p  (weight_reg),
                .depth_eff (depth_eff),
                .stage_in  (stage[lvl]),
                .stage_out (stage[lvl+1])
            );
        end
    endgenerate

    // Output register and skid slot
    bmcm_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage_in   (stage[MAX_LEVELS]),
        .advance    (advance),
        .skid_full  (skid_full),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_mass  (cell_mass),
        .echo_index (echo_index)
    );

    // Checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full |-> out_valid)
        else $error("skid slot full while output register empty");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full) |-> $past(out_valid && out_stall))
        else $error("skid slot filled without a stalled output");

    a_mass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cell_mass <= MASS_ONE))
        else $error("cell mass above one");

    a_depth_sat: assert property (@(posedge clk) disable iff (!rst_n)
        depth_eff <= MAX_DEPTH)
        else $error("effective depth beyond pipeline length");

endmodule

// File: rtl/bmcm_level.sv
// One subdivision level of the cell mass pipeline: one multiply, one register.
// Depends on bmcm_pkg.
module bmcm_level
    import bmcm_pkg::*;
#(
    parameter int LEVEL = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [WEIGHT_W-1:0] weight_p,
    input  logic [DEPTH_W-1:0]  depth_eff,
    input  bmcm_stage_t         stage_in,
    output bmcm_stage_t         stage_out
);

    localparam logic [DEPTH_W-1:0] LEVEL_CODE = DEPTH_W'(LEVEL);

    logic                valid_reg;
    logic [MASS_W-1:0]   mass_reg;
    logic [MASS_W-1:0]   mass_next;
    logic [IDX_W-1:0]    index_reg;
    logic                bit_set;
    logic                active;
    logic [FACTOR_W-1:0] factor;
    logic [PROD_W-1:0]   product;

    // Index bits above the field width read as clear
    generate
        if (LEVEL < IDX_W) begin : g_bit
            assign bit_set = stage_in.index[LEVEL];
        end
        else begin : g_nobit
            assign bit_set = 1'b0;
        end
    endgenerate

    // Pick p0 or 1-p0, multiply, truncate back to Q1.32; levels at or past depth_eff pass the mass through
    assign active  = (LEVEL_CODE < depth_eff);
    assign factor  = bit_set ? (WEIGHT_ONE - FACTOR_W'(weight_p)) : FACTOR_W'(weight_p);
    assign product = PROD_W'(stage_in.mass) * PROD_W'(factor);
    assign mass_next = active ? product[MASS_W+WEIGHT_W-1:WEIGHT_W] : stage_in.mass;

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mass_reg  <= mass_next;
            index_reg <= stage_in.index;
        end
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.mass  = mass_reg;
    assign stage_out.index = index_reg;

endmodule

// File: rtl/bmcm_skid.sv
// Output register with one skid slot; frees the pipeline from the output stall.
// Depends on bmcm_pkg.
module bmcm_skid
    import bmcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bmcm_stage_t       stage_in,
    output logic              advance,
    output logic              skid_full,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [MASS_W-1:0] cell_mass,
    output logic [IDX_W-1:0]  echo_index
);

    logic              out_valid_reg;
    logic [MASS_W-1:0] out_mass_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic              skid_full_reg;
    logic [MASS_W-1:0] skid_mass_reg;
    logic [IDX_W-1:0]  skid_index_reg;
    logic              out_free;
    logic              arriving;

    // Pipeline moves whenever the skid slot is empty
    assign advance  = !skid_full_reg;
    assign arriving = advance && stage_in.valid;
    assign out_free = !out_valid_reg || !out_stall;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= skid_full_reg || arriving;
            skid_full_reg <= 1'b0;
        end
        else if (arriving)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_full_reg)
            begin
                out_mass_reg  <= skid_mass_reg;
                out_index_reg <= skid_index_reg;
            end
            else
            begin
                out_mass_reg  <= stage_in.mass;
                out_index_reg <= stage_in.index;
            end
        end
        else if (arriving)
        begin
            skid_mass_reg  <= stage_in.mass;
            skid_index_reg <= stage_in.index;
        end
    end

    assign skid_full  = skid_full_reg;
    assign out_valid  = out_valid_reg;
    assign cell_mass  = out_mass_reg;
    assign echo_index = out_index_reg;

endmodule
